// ----- rtl/clle_pkg.sv -----
// Shared types and codes for the cursor linked list engine.
package clle_pkg;

  typedef enum logic [3:0] {
    ACT_INS_FRONT = 4'd0,
    ACT_INS_REAR  = 4'd1,
    ACT_RM_FRONT  = 4'd2,
    ACT_RM_REAR   = 4'd3,
    ACT_RM_CUR    = 4'd4,
    ACT_NEXT      = 4'd5,
    ACT_PREV      = 4'd6,
    ACT_SEARCH    = 4'd7,
    ACT_READ      = 4'd8,
    ACT_CLEAR     = 4'd9
  } action_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ----- rtl/clle_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module clle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/cursor_linked_list_engine.sv -----
// Top level: list sequencer over link and value memories.
//
// Channel | Dir | Payload
// in_*    | in  | tdata = {value, action}  (action [3:0], value above)
// out_*   | out | tdata = {node_count, cursor_value, cursor_valid, status}
//
// A request occupies the engine from acceptance until its result is loaded. Search
// reads the link and value of each node visited in the same cycle.
// Clear needs no link writes: the sentinel links live in front_r/rear_r.
// Reset starts a pass zeroing every link entry; no request is taken until it ends.
// The result sits in an output register; a following request runs up to its
// output step and stalls there until the pending result is taken.
module cursor_linked_list_engine
  import clle_pkg::*;
#(
  parameter int POOL_SLOTS = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // action[3:0], value[35:4], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], cursor_valid[2],
                                  // cursor_value[34:3], node_count[38:35]
);

  localparam int AW = $clog2(POOL_SLOTS);
  localparam int CW = $clog2(POOL_SLOTS + 1);

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RD0   = 10'b0000000100,  // decide from sentinel links in front_r/rear_r
    S_RDA   = 10'b0000001000,  // read node A links
    S_RDB   = 10'b0000010000,  // read node A value / wait
    S_WR1   = 10'b0000100000,
    S_WR2   = 10'b0001000000,
    S_SRCH  = 10'b0010000000,
    S_CVAL  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // memories: links and values
  logic            fw_we, bw_we, val_we;
  logic [AW-1:0]   fw_wa, bw_wa, val_wa, lnk_ra, val_ra;
  logic [AW-1:0]   fw_wd, bw_wd, fw_rd, bw_rd;
  logic [VALUE_BITS-1:0] val_wd, val_rd;

  clle_ram #(.WIDTH(AW), .DEPTH(POOL_SLOTS)) u_fw (
    .clk, .we(fw_we), .waddr(fw_wa), .wdata(fw_wd), .raddr(lnk_ra), .rdata(fw_rd));
  clle_ram #(.WIDTH(AW), .DEPTH(POOL_SLOTS)) u_bw (
    .clk, .we(bw_we), .waddr(bw_wa), .wdata(bw_wd), .raddr(lnk_ra), .rdata(bw_rd));
  clle_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_SLOTS)) u_val (
    .clk, .we(val_we), .waddr(val_wa), .wdata(val_wd), .raddr(val_ra), .rdata(val_rd));

  logic [3:0]            act_r, act_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [POOL_SLOTS-1:0] free_r, free_nxt;
  logic [AW-1:0]         cur_r, cur_nxt;
  logic [CW-1:0]         len_r, len_nxt;
  logic [AW-1:0]         front_r, front_nxt, rear_r, rear_nxt;
  logic [AW-1:0]         a_r, a_nxt, pr_r, pr_nxt, nx_r, nx_nxt, nn_r, nn_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [1:0]            st_r, st_nxt;
  logic                  ov_r, ov_nxt;
  logic [39:0]           od_r, od_nxt;

  // lowest free slot, excluding the sentinel
  logic [AW-1:0] low_free;
  logic          any_free;
  always_comb begin
    low_free = '0;
    any_free = 1'b0;
    for (int i = POOL_SLOTS - 1; i >= 1; i--) begin
      if (free_r[i]) begin
        low_free = AW'(i);
        any_free = 1'b1;
      end
    end
  end

  logic [VALUE_BITS-1:0] in_val;
  assign in_val = in_tdata[4 +: VALUE_BITS];

  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r; key_nxt = key_r; free_nxt = free_r; cur_nxt = cur_r;
    len_nxt = len_r; front_nxt = front_r; rear_nxt = rear_r;
    a_nxt = a_r; pr_nxt = pr_r; nx_nxt = nx_r; nn_nxt = nn_r; cnt_nxt = cnt_r;
    st_nxt = st_r; ov_nxt = ov_r; od_nxt = od_r;
    fw_we = 1'b0; bw_we = 1'b0; val_we = 1'b0;
    fw_wa = '0; bw_wa = '0; val_wa = '0; fw_wd = '0; bw_wd = '0;
    val_wd = key_r; lnk_ra = '0; val_ra = cur_r;
    unique case (state_r)
      // zero every link entry
      S_INIT: begin
        fw_we = 1'b1; bw_we = 1'b1;
        fw_wa = cnt_r[AW-1:0]; bw_wa = cnt_r[AW-1:0];
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(POOL_SLOTS - 1)) begin
          state_nxt = S_IDLE;
          front_nxt = '0; rear_nxt = '0;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt = in_tdata[3:0];
          key_nxt = in_val;
          st_nxt = ST_OK;
          cnt_nxt = '0;
          state_nxt = S_RD0;
        end
      end
      // decide the action; sentinel links are mirrored in front_r/rear_r
      S_RD0: begin
        state_nxt = S_WR1;
        case (act_r)
          ACT_INS_FRONT, ACT_INS_REAR: begin
            if (!any_free) begin
              st_nxt = ST_FULL; state_nxt = S_CVAL;
            end else begin
              nn_nxt = low_free;
              if (act_r == ACT_INS_FRONT) begin
                pr_nxt = '0; nx_nxt = front_r;
              end else begin
                pr_nxt = rear_r; nx_nxt = '0;
              end
            end
          end
          ACT_RM_FRONT, ACT_RM_REAR, ACT_RM_CUR: begin
            if (act_r == ACT_RM_FRONT) a_nxt = front_r;
            else if (act_r == ACT_RM_REAR) a_nxt = rear_r;
            else a_nxt = cur_r;
            if ((act_r == ACT_RM_CUR && cur_r == '0) ||
                (act_r != ACT_RM_CUR && front_r == '0)) begin
              st_nxt = ST_EMPTY; state_nxt = S_CVAL;
            end else begin
              state_nxt = S_RDA;
            end
          end
          ACT_NEXT, ACT_PREV: begin
            a_nxt = cur_r;
            if (front_r == '0 || cur_r == '0) begin
              st_nxt = ST_EMPTY; state_nxt = S_CVAL;
            end else begin
              state_nxt = S_RDA;
            end
          end
          ACT_SEARCH: begin
            a_nxt = front_r;
            st_nxt = ST_NOT_FOUND;
            state_nxt = (front_r == '0) ? S_CVAL : S_RDA;
          end
          ACT_READ: begin
            st_nxt = (cur_r == '0) ? ST_EMPTY : ST_OK;
            state_nxt = S_CVAL;
          end
          ACT_CLEAR: begin
            free_nxt = {{(POOL_SLOTS-1){1'b1}}, 1'b0};
            cur_nxt = '0; len_nxt = '0; front_nxt = '0; rear_nxt = '0;
            state_nxt = S_CVAL;
          end
          default: state_nxt = S_CVAL;
        endcase
      end
      // issue link and value read of node A
      S_RDA: begin
        lnk_ra = a_r;
        val_ra = a_r;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        state_nxt = S_WR1;
        case (act_r)
          ACT_NEXT: begin
            if (fw_rd == '0) st_nxt = ST_EMPTY; else cur_nxt = fw_rd;
            state_nxt = S_CVAL;
          end
          ACT_PREV: begin
            if (bw_rd == '0) st_nxt = ST_EMPTY; else cur_nxt = bw_rd;
            state_nxt = S_CVAL;
          end
          ACT_SEARCH: begin
            cnt_nxt = cnt_r + CW'(1);
            if (val_rd == key_r) begin
              cur_nxt = a_r; st_nxt = ST_OK; state_nxt = S_CVAL;
            end else if (fw_rd == '0 || cnt_r == CW'(POOL_SLOTS - 1)) begin
              state_nxt = S_CVAL;
            end else begin
              a_nxt = fw_rd; state_nxt = S_SRCH;
            end
          end
          default: begin
            pr_nxt = bw_rd; nx_nxt = fw_rd;
          end
        endcase
      end
      S_SRCH: begin
        lnk_ra = a_r; val_ra = a_r;
        state_nxt = S_RDB;
      end
      // link and value writes: insert or unlink
      S_WR1: begin
        state_nxt = S_WR2;
        if (act_r == ACT_INS_FRONT || act_r == ACT_INS_REAR) begin
          val_we = 1'b1; val_wa = nn_r;
          fw_we = 1'b1; fw_wa = nn_r; fw_wd = nx_r;
          bw_we = 1'b1; bw_wa = nn_r; bw_wd = pr_r;
        end else begin
          fw_we = 1'b1; fw_wa = pr_r; fw_wd = nx_r;
          bw_we = 1'b1; bw_wa = nx_r; bw_wd = pr_r;
          if (pr_r == '0) front_nxt = nx_r;
          if (nx_r == '0) rear_nxt = pr_r;
        end
      end
      S_WR2: begin
        state_nxt = S_CVAL;
        if (act_r == ACT_INS_FRONT || act_r == ACT_INS_REAR) begin
          fw_we = 1'b1; fw_wa = pr_r; fw_wd = nn_r;
          bw_we = 1'b1; bw_wa = nx_r; bw_wd = nn_r;
          if (pr_r == '0) front_nxt = nn_r;
          if (nx_r == '0) rear_nxt = nn_r;
          free_nxt[nn_r] = 1'b0;
          cur_nxt = nn_r;
          len_nxt = len_r + CW'(1);
        end else begin
          free_nxt[a_r] = 1'b1;
          if (len_r != '0) len_nxt = len_r - CW'(1);
          cur_nxt = (pr_r == '0) ? front_r : pr_r;
        end
      end
      // read the cursor value
      S_CVAL: begin
        val_ra = cur_r;
        state_nxt = S_OUT;
      end
      // load the output register once the previous result has left
      S_OUT: begin
        val_ra = cur_r;
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = '0;
          od_nxt[1:0] = st_r;
          od_nxt[2] = (cur_r != '0);
          od_nxt[34:3] = (cur_r != '0) ? 32'(val_rd) : 32'd0;
          od_nxt[38:35] = 4'(len_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (ov_r && out_tready && state_r != S_OUT) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      free_r  <= {{(POOL_SLOTS-1){1'b1}}, 1'b0};
      cur_r   <= '0;
      len_r   <= '0;
      front_r <= '0;
      rear_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      free_r  <= free_nxt;
      cur_r   <= cur_nxt;
      len_r   <= len_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
    end
    act_r <= act_nxt; key_r <= key_nxt; a_r <= a_nxt; pr_r <= pr_nxt;
    nx_r <= nx_nxt; nn_r <= nn_nxt; st_r <= st_nxt; od_r <= od_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // sentinel is never free
  a_sent_busy: assert property (@(posedge clk) disable iff (!rst_n) !free_r[0])
    else $error("sentinel marked free");
  // an empty list has the cursor on the sentinel
  a_empty_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && front_r == '0) |-> cur_r == '0)
    else $error("cursor off sentinel on empty list");
  // a pending result stays valid and stable until it is accepted
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");

endmodule
